// ===== rtl/euler_convective_flux_core_macros.svh =====
// Assertion macros for the Euler convective flux core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef EULER_CONVECTIVE_FLUX_CORE_MACROS_SVH
`define EULER_CONVECTIVE_FLUX_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define ECF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecf assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define ECF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecf assertion failed");
`else
`define ECF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ECF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ecf_pkg.sv =====
// Shared constants, register codes and saturation helpers for the flux core.
// No dependencies; imported by euler_convective_flux_core.
package ecf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 20;
    localparam int CFG_WIDTH      = 31;
    localparam int ADDR_WIDTH     = 2;
    localparam int DIMS_WIDTH     = 2;
    localparam int SAT_WIDTH      = 128;

    // Register indexes of the configuration port
    localparam logic [ADDR_WIDTH-1:0] REG_NUM_DIMS     = 2'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_GAMMA_M1     = 2'd1;
    localparam logic [ADDR_WIDTH-1:0] REG_INV_GAMMA_M1 = 2'd2;
    localparam logic [ADDR_WIDTH-1:0] REG_P_FLOOR      = 2'd3;

    // Dimension code for two dimensions; every other code means three
    localparam logic [DIMS_WIDTH-1:0] DIMS_TWO = 2'd2;

    // Reset values
    localparam logic [DIMS_WIDTH-1:0] NUM_DIMS_RST     = 2'd3;
    localparam logic [CFG_WIDTH-1:0]  GAMMA_M1_RST     = 31'd419430;
    localparam logic [CFG_WIDTH-1:0]  INV_GAMMA_M1_RST = 31'd2621440;
    localparam logic [CFG_WIDTH-1:0]  P_FLOOR_RST      = 31'd1;

    typedef logic signed [SAT_WIDTH-1:0] wide_t;

    // Clip a wide signed value to the range of a w-bit signed number
    function automatic wide_t sat_to(input wide_t x, input int unsigned w);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (x > hi)
            return hi;
        else if (x < lo)
            return lo;
        return x;
    endfunction

    // Drop fraction bits of a full product (floor), then saturate
    function automatic wide_t fx_round(input wide_t x, input int unsigned f,
                                       input int unsigned w);
        return sat_to(x >>> f, w);
    endfunction

endpackage

// ===== rtl/ecf_div.sv =====
// Pipelined fixed-point divider: (a * 2^FRAC_BITS) / b, truncated, saturated.
// One quotient bit per stage; standalone, no package dependencies.
module ecf_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic signed [DATA_WIDTH-1:0] quotient
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic ovf;
        logic zdiv;
        logic a_neg;
        logic q_neg;
    } dflag_t;

    logic [W-1:0]  rem_reg  [W+1];
    logic [W-1:0]  lowq_reg [W+1];
    logic [W-1:0]  b_reg    [W+1];
    dflag_t        flag_reg [W+1];
    logic signed [W-1:0] res_reg;

    logic [W-1:0]  a_mag;
    logic [W-1:0]  b_mag;
    logic [NW-1:0] num;
    dflag_t        flag_next;

    // Magnitudes, sign of the result and overflow test
    always_comb
    begin
        a_mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;
        b_mag = divisor[W-1] ? (~divisor + 1'b1) : divisor;
        num   = {a_mag, {F{1'b0}}};
        flag_next.ovf   = ({{W{1'b0}}, num} >= {{F{1'b0}}, b_mag, {W{1'b0}}});
        flag_next.zdiv  = (divisor == '0);
        flag_next.a_neg = dividend[W-1];
        flag_next.q_neg = dividend[W-1] ^ divisor[W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= W'(num[NW-1:W]);
            lowq_reg[0] <= num[W-1:0];
            b_reg[0]    <= b_mag;
            flag_reg[0] <= flag_next;
        end
    end

    // Restoring steps, one quotient bit each
    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [W:0] shifted;
        logic [W:0] diff;
        logic       ge;

        always_comb
        begin
            shifted = {rem_reg[k-1], lowq_reg[k-1][W-1]};
            diff    = shifted - {1'b0, b_reg[k-1]};
            ge      = (shifted >= {1'b0, b_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[W-1:0] : shifted[W-1:0];
                lowq_reg[k] <= {lowq_reg[k-1][W-2:0], ge};
                b_reg[k]    <= b_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    // Apply sign and saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (flag_reg[W].zdiv)
                res_reg <= flag_reg[W].a_neg ? VMIN : VMAX;
            else if (flag_reg[W].ovf)
                res_reg <= flag_reg[W].q_neg ? VMIN : VMAX;
            else if (!flag_reg[W].q_neg)
                res_reg <= lowq_reg[W][W-1] ? VMAX : signed'(lowq_reg[W]);
            else if (lowq_reg[W] > {1'b1, {(W-1){1'b0}}})
                res_reg <= VMIN;
            else
                res_reg <= signed'(~lowq_reg[W] + 1'b1);
        end
    end

    assign quotient = res_reg;

endmodule

// ===== rtl/euler_convective_flux_core.sv =====
// Euler convective flux core: top level with stream ports and config registers.
// Depends on ecf_pkg, ecf_div and euler_convective_flux_core_macros.svh.
//
// Usage: one cell face enters per item on the s_* stream; one flux result leaves
// per item on the m_* stream, in order. The core is a fixed pipeline, and a new
// item can be accepted every cycle while s_tready is high. The depth is set by
// the two bit-per-stage dividers (contravariant velocity and |m|^2/rho) that
// run side by side, plus the multiply, saturate and pressure floor stages
// around them.
// The output register is backed by a one-entry skid stage: when the receiver
// holds m_tready low, the core keeps taking items until the skid stage fills,
// then s_tready drops and the whole pipeline holds; nothing is lost or doubled.
// Reset clears all valid bits and loads the default gas constants (3 dims,
// gamma-1 = 0.4, 1/(gamma-1) = 2.5, pressure floor = 1 LSB). Configuration
// writes take effect at the next edge and are meant for when the core is idle.
`include "euler_convective_flux_core_macros.svh"
module euler_convective_flux_core #(
    parameter int DATA_WIDTH = ecf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ecf_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // density, mom_x, mom_y, mom_z, total_energy, normal_x, normal_y, normal_z
    input  logic [((8*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // flux_mass, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy, energy_corrected
    output logic [((6*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
    // pressure_clamped
    output logic                                    m_tuser,
    input  logic                                    cfg_we,
    input  logic [ecf_pkg::ADDR_WIDTH-1:0]          cfg_addr,
    input  logic [ecf_pkg::CFG_WIDTH-1:0]           cfg_wdata
);

    import ecf_pkg::*;

    localparam int W       = DATA_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int CW      = CFG_WIDTH;
    localparam int PW      = (W > CW) ? W : CW + 1;
    localparam int XW      = SAT_WIDTH;
    localparam int OUT_W   = ((6*W+7)/8)*8;
    localparam int DIV_LAT = W + 2;

    typedef logic signed [W-1:0]      val_t;
    typedef logic signed [PW-1:0]     pval_t;
    typedef logic signed [2*W-1:0]    prod_t;

    typedef struct packed {
        val_t            rho;
        logic [2:0][W-1:0] mom;
        val_t            et;
        logic [2:0][W-1:0] nrm;
    } cell_t;

    typedef struct packed {
        logic [2:0][W-1:0] nrm;
        val_t            et;
        val_t            ke;
        val_t            t;
        val_t            vel;
        val_t            fmass;
        logic [2:0][W-1:0] mv;
        pval_t           p;
        logic            clamp;
        logic [2:0][W-1:0] fmom;
        val_t            ht;
        val_t            fe;
    } tail_t;

    localparam val_t HALF = val_t'(1) << (F - 1);

    // Configuration registers
    logic [DIMS_WIDTH-1:0] num_dims_reg;
    logic [CW-1:0]         gm1_reg;
    logic [CW-1:0]         inv_gm1_reg;
    logic [CW-1:0]         floor_reg;
    logic                  two_d;

    // Flow control
    logic                  en;
    logic                  v1_reg, v2_reg, v3_reg;
    logic                  vdl_reg [DIV_LAT];
    logic                  v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic                  out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0]      out_data_reg, skid_data_reg, last_data;
    logic                  out_user_reg, skid_user_reg;

    // Datapath
    cell_t                 in_cell;
    cell_t                 c1_reg, c2_reg, c3_reg;
    cell_t                 cdl_reg [DIV_LAT];
    prod_t                 pd1_reg [3];
    prod_t                 ps1_reg [3];
    val_t                  dot2_next, sq2_next, dot2_reg, sq2_reg;
    val_t                  vel_q, sqd_q, vel3_reg;
    prod_t                 ke3_reg, rv3_reg;
    prod_t                 mv3_reg [3];
    tail_t                 t4_next, t4_reg, t5_reg, t6_next, t6_reg, t7_reg;
    tail_t                 t8_next, t8_reg, t9_reg, t10_next, t10_reg;
    logic signed [CW+W:0]  pp5_reg;
    logic signed [W+PW-1:0] np7_reg [3];
    logic signed [PW+CW:0] ip7_reg;
    prod_t                 hv9_reg;

    assign two_d    = (num_dims_reg == DIMS_TWO);
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= NUM_DIMS_RST;
            gm1_reg      <= GAMMA_M1_RST;
            inv_gm1_reg  <= INV_GAMMA_M1_RST;
            floor_reg    <= P_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NUM_DIMS:     num_dims_reg <= cfg_wdata[DIMS_WIDTH-1:0];
                REG_GAMMA_M1:     gm1_reg      <= cfg_wdata;
                REG_INV_GAMMA_M1: inv_gm1_reg  <= cfg_wdata;
                REG_P_FLOOR:      floor_reg    <= cfg_wdata;
            endcase
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
                vdl_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg     <= s_tvalid;
            v2_reg     <= v1_reg;
            vdl_reg[0] <= v2_reg;
            for (int k = 1; k < DIV_LAT; k++)
                vdl_reg[k] <= vdl_reg[k-1];
            v3_reg  <= vdl_reg[DIV_LAT-1];
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    // Unpack the input item
    always_comb
    begin
        in_cell.rho = s_tdata[0*W +: W];
        for (int i = 0; i < 3; i++)
        begin
            in_cell.mom[i] = s_tdata[(1+i)*W +: W];
            in_cell.nrm[i] = s_tdata[(5+i)*W +: W];
        end
        in_cell.et = s_tdata[4*W +: W];
    end

    // Stage 1: momentum products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= in_cell;
            for (int i = 0; i < 3; i++)
            begin
                pd1_reg[i] <= signed'(in_cell.mom[i]) * signed'(in_cell.nrm[i]);
                ps1_reg[i] <= signed'(in_cell.mom[i]) * signed'(in_cell.mom[i]);
            end
        end
    end

    // Stage 2: saturating dot product and |m|^2
    always_comb
    begin
        wide_t acc_d;
        wide_t acc_s;
        acc_d = fx_round(XW'(pd1_reg[0]), F, W);
        acc_s = fx_round(XW'(ps1_reg[0]), F, W);
        acc_d = sat_to(acc_d + fx_round(XW'(pd1_reg[1]), F, W), W);
        acc_s = sat_to(acc_s + fx_round(XW'(ps1_reg[1]), F, W), W);
        if (!two_d)
        begin
            acc_d = sat_to(acc_d + fx_round(XW'(pd1_reg[2]), F, W), W);
            acc_s = sat_to(acc_s + fx_round(XW'(ps1_reg[2]), F, W), W);
        end
        dot2_next = W'(acc_d);
        sq2_next  = W'(acc_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg   <= c1_reg;
            dot2_reg <= dot2_next;
            sq2_reg  <= sq2_next;
        end
    end

    // Divide by density: velocity and |m|^2 / rho
    ecf_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div_vel (
        .clk      (clk),
        .en       (en),
        .dividend (dot2_reg),
        .divisor  (c2_reg.rho),
        .quotient (vel_q)
    );

    ecf_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div_sq (
        .clk      (clk),
        .en       (en),
        .dividend (sq2_reg),
        .divisor  (c2_reg.rho),
        .quotient (sqd_q)
    );

    // Hold the cell alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdl_reg[0] <= c2_reg;
            for (int k = 1; k < DIV_LAT; k++)
                cdl_reg[k] <= cdl_reg[k-1];
        end
    end

    // Stage 3: kinetic energy and velocity products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg   <= cdl_reg[DIV_LAT-1];
            vel3_reg <= vel_q;
            ke3_reg  <= HALF * sqd_q;
            rv3_reg  <= signed'(cdl_reg[DIV_LAT-1].rho) * vel_q;
            for (int i = 0; i < 3; i++)
                mv3_reg[i] <= signed'(cdl_reg[DIV_LAT-1].mom[i]) * vel_q;
        end
    end

    // Stage 4: round products, internal energy difference
    always_comb
    begin
        wide_t ke_w;
        t4_next       = '0;
        ke_w          = fx_round(XW'(ke3_reg), F, W);
        t4_next.nrm   = c3_reg.nrm;
        t4_next.et    = c3_reg.et;
        t4_next.ke    = W'(ke_w);
        t4_next.t     = W'(sat_to(XW'(c3_reg.et) - ke_w, W));
        t4_next.vel   = vel3_reg;
        t4_next.fmass = W'(fx_round(XW'(rv3_reg), F, W));
        for (int i = 0; i < 3; i++)
            t4_next.mv[i] = W'(fx_round(XW'(mv3_reg[i]), F, W));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t4_reg <= t4_next;
    end

    // Stage 5: pressure product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t5_reg  <= t4_reg;
            pp5_reg <= signed'({1'b0, gm1_reg}) * t4_reg.t;
        end
    end

    // Stage 6: pressure floor
    always_comb
    begin
        wide_t p_w;
        wide_t floor_w;
        t6_next = t5_reg;
        p_w     = fx_round(XW'(pp5_reg), F, W);
        floor_w = XW'(signed'({1'b0, floor_reg}));
        if (p_w < floor_w)
        begin
            t6_next.p     = PW'(floor_w);
            t6_next.clamp = 1'b1;
        end
        else
        begin
            t6_next.p     = PW'(p_w);
            t6_next.clamp = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t6_reg <= t6_next;
    end

    // Stage 7: pressure terms and rebuilt internal energy
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t7_reg  <= t6_reg;
            ip7_reg <= t6_reg.p * signed'({1'b0, inv_gm1_reg});
            for (int i = 0; i < 3; i++)
                np7_reg[i] <= signed'(t6_reg.nrm[i]) * t6_reg.p;
        end
    end

    // Stage 8: corrected energy, enthalpy, momentum flux
    always_comb
    begin
        wide_t et_w;
        t8_next = t7_reg;
        if (t7_reg.clamp)
            et_w = sat_to(fx_round(XW'(ip7_reg), F, W) + XW'(t7_reg.ke), W);
        else
            et_w = XW'(t7_reg.et);
        t8_next.et = W'(et_w);
        t8_next.ht = W'(sat_to(et_w + XW'(t7_reg.p), W));
        for (int i = 0; i < 3; i++)
        begin
            if (i == 2 && two_d)
                t8_next.fmom[i] = '0;
            else
                t8_next.fmom[i] = W'(sat_to(XW'(signed'(t7_reg.mv[i]))
                                  + fx_round(XW'(np7_reg[i]), F, W), W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t8_reg <= t8_next;
    end

    // Stage 9: energy flux product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t9_reg  <= t8_reg;
            hv9_reg <= t8_reg.ht * t8_reg.vel;
        end
    end

    // Stage 10: energy flux rounding
    always_comb
    begin
        t10_next    = t9_reg;
        t10_next.fe = W'(fx_round(XW'(hv9_reg), F, W));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t10_reg <= t10_next;
    end

    assign last_data = OUT_W'({t10_reg.et, t10_reg.fe, t10_reg.fmom[2], t10_reg.fmom[1],
                               t10_reg.fmom[0], t10_reg.fmass});

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (!out_valid_reg || m_tready)
                out_valid_reg <= v10_reg;
            else if (v10_reg)
                skid_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_data_reg <= last_data;
                out_user_reg <= t10_reg.clamp;
            end
            else
            begin
                skid_data_reg <= last_data;
                skid_user_reg <= t10_reg.clamp;
            end
        end
        else if (m_tready)
        begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `ECF_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ECF_ASSERT_NXT(a_skid_fill, clk, rst_n, en && v10_reg && out_valid_reg && !m_tready, skid_valid_reg)
    `ECF_ASSERT_IMP(a_two_d_no_z, clk, rst_n, out_valid_reg && two_d, out_data_reg[4*W-1:3*W] == '0)
    `ECF_ASSERT_IMP(a_clamp_at_floor, clk, rst_n, v6_reg && t6_reg.clamp, t6_reg.p == PW'(floor_reg))

endmodule

// ===== dv/euler_convective_flux_core_test.sv =====
// Self-checking bench for euler_convective_flux_core: face items in, flux items out.
// Depends on ecf_pkg and the core RTL; prediction is computed in this file.
`timescale 1ns / 1ps

module euler_convective_flux_core_test;
    import ecf_pkg::*;

    localparam int DW = 32;
    localparam int FB = 20;
    localparam int DRAIN_CYCLES = 80;

    typedef logic signed [127:0] acc_t;
    typedef logic signed [DW-1:0] q_t;

    typedef struct {
        q_t rho;
        q_t mom [3];
        q_t energy;
        q_t nrm [3];
    } face_t;

    typedef struct {
        q_t mass;
        q_t fmom [3];
        q_t fenergy;
        q_t ecorr;
        logic clamped;
    } flux_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [8*DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [6*DW-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [ADDR_WIDTH-1:0] cfg_addr = REG_NUM_DIMS;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    // gas constants as the core should hold them
    logic [DIMS_WIDTH-1:0] gas_dims = NUM_DIMS_RST;
    logic [CFG_WIDTH-1:0] gas_gm1 = GAMMA_M1_RST;
    logic [CFG_WIDTH-1:0] gas_inv_gm1 = INV_GAMMA_M1_RST;
    logic [CFG_WIDTH-1:0] gas_floor = P_FLOOR_RST;

    face_t faces_to_send [$];
    flux_t flux_due [$];
    face_t face_on_bus;
    logic face_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_age = 0;
    int mismatches = 0;

    euler_convective_flux_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic acc_t clip(input acc_t x);
        acc_t hi;
        acc_t lo;
        hi = (acc_t'(1) <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // product with floor rounding of the dropped fraction
    function automatic acc_t qmul(input acc_t a, input acc_t b);
        return clip((a * b) >>> FB);
    endfunction

    // quotient truncated toward zero; divide by zero goes to the rail
    function automatic acc_t qdiv(input acc_t a, input acc_t b);
        if (b == 0)
            return (a >= 0) ? clip(acc_t'(1) <<< 100) : clip(-(acc_t'(1) <<< 100));
        return clip((a <<< FB) / b);
    endfunction

    function automatic flux_t face_flux(input face_t f);
        flux_t r;
        acc_t rho, et, dot, sq, vel, ke, p;
        int dims;
        rho = f.rho;
        et = f.energy;
        dot = 0;
        sq = 0;
        dims = (gas_dims == DIMS_TWO) ? 2 : 3;
        for (int i = 0; i < dims; i++) begin
            dot = clip(dot + qmul(f.mom[i], f.nrm[i]));
            sq = clip(sq + qmul(f.mom[i], f.mom[i]));
        end
        vel = qdiv(dot, rho);
        ke = qmul(acc_t'(1) <<< (FB - 1), qdiv(sq, rho));
        p = qmul(acc_t'(gas_gm1), clip(et - ke));
        r.clamped = 1'b0;
        if (p < acc_t'(gas_floor)) begin
            p = acc_t'(gas_floor);
            et = clip(qmul(p, acc_t'(gas_inv_gm1)) + ke);
            r.clamped = 1'b1;
        end
        for (int i = 0; i < 3; i++)
            r.fmom[i] = (i < dims) ? q_t'(clip(qmul(f.mom[i], vel) + qmul(f.nrm[i], p))) : '0;
        r.mass = q_t'(qmul(rho, vel));
        r.fenergy = q_t'(qmul(clip(et + p), vel));
        r.ecorr = q_t'(et);
        return r;
    endfunction

    // feed items at the falling edge in bursts separated by random gaps, some of zero length
    always @(negedge clk) begin
        if (!s_tvalid || face_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (faces_to_send.size() > 0) begin
                face_on_bus = faces_to_send.pop_front();
                s_tdata <= {face_on_bus.nrm[2], face_on_bus.nrm[1], face_on_bus.nrm[0],
                            face_on_bus.energy, face_on_bus.mom[2], face_on_bus.mom[1],
                            face_on_bus.mom[0], face_on_bus.rho};
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: switch between always ready, half and rarely ready
    always @(negedge clk) begin
        if (stall_age == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_age <= $urandom_range(16, 96);
        end else begin
            stall_age <= stall_age - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // record the expected flux of each accepted face
    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            flux_due.push_back(face_flux(face_on_bus));
            face_taken <= 1'b1;
        end else begin
            face_taken <= 1'b0;
        end
    end

    // compare each delivered flux item with the oldest expectation
    always @(posedge clk) begin
        flux_t want;
        flux_t got;
        if (m_tvalid && m_tready) begin
            got.mass = m_tdata[0*DW +: DW];
            got.fmom[0] = m_tdata[1*DW +: DW];
            got.fmom[1] = m_tdata[2*DW +: DW];
            got.fmom[2] = m_tdata[3*DW +: DW];
            got.fenergy = m_tdata[4*DW +: DW];
            got.ecorr = m_tdata[5*DW +: DW];
            got.clamped = m_tuser;
            if (flux_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected flux item at %0t", $realtime);
            end else begin
                want = flux_due.pop_front();
                if (got.mass !== want.mass || got.fmom[0] !== want.fmom[0]
                    || got.fmom[1] !== want.fmom[1] || got.fmom[2] !== want.fmom[2]
                    || got.fenergy !== want.fenergy || got.ecorr !== want.ecorr
                    || got.clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("flux mismatch at %0t: exp %h %h %h %h %h %h %b",
                            $realtime, want.mass, want.fmom[0], want.fmom[1], want.fmom[2],
                            want.fenergy, want.ecorr, want.clamped);
                        $display(" got %h %h %h %h %h %h %b", got.mass, got.fmom[0],
                            got.fmom[1], got.fmom[2], got.fenergy, got.ecorr, got.clamped);
                    end
                end
            end
        end
    end

    function automatic q_t small_signed(input int unsigned range);
        return q_t'($signed($urandom_range(0, 2 * range)) - $signed(range));
    endfunction

    function automatic q_t any_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return q_t'($urandom);
        endcase
    endfunction

    function automatic face_t make_face(input q_t rho, input q_t mx, input q_t my,
                                        input q_t mz, input q_t e, input q_t nx,
                                        input q_t ny, input q_t nz);
        face_t f;
        f.rho = rho;
        f.mom[0] = mx;
        f.mom[1] = my;
        f.mom[2] = mz;
        f.energy = e;
        f.nrm[0] = nx;
        f.nrm[1] = ny;
        f.nrm[2] = nz;
        return f;
    endfunction

    // mostly physical faces, some raw words, a few zero densities
    function automatic face_t random_face();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
            return make_face(q_t'($urandom_range(1 << 18, 6 << 20)),
                small_signed(3 << 20), small_signed(3 << 20), small_signed(3 << 20),
                q_t'($urandom_range(0, 12 << 20)) - (kind == 0 ? q_t'(1 << 20) : q_t'(0)),
                small_signed(1 << 20), small_signed(1 << 20), small_signed(1 << 20));
        if (kind == 7)
            return make_face('0, small_signed(1 << 22), small_signed(1 << 22),
                small_signed(1 << 22), small_signed(1 << 23), small_signed(1 << 20),
                small_signed(1 << 20), small_signed(1 << 20));
        return make_face(any_word(), any_word(), any_word(), any_word(), any_word(),
            any_word(), any_word(), any_word());
    endfunction

    task automatic wait_idle();
        while (faces_to_send.size() > 0 || s_tvalid || flux_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NUM_DIMS: gas_dims = val[DIMS_WIDTH-1:0];
            REG_GAMMA_M1: gas_gm1 = val;
            REG_INV_GAMMA_M1: gas_inv_gm1 = val;
            default: gas_floor = val;
        endcase
    endtask

    task automatic set_gas(input logic [DIMS_WIDTH-1:0] dims, input logic [CFG_WIDTH-1:0] gm1,
                           input logic [CFG_WIDTH-1:0] inv, input logic [CFG_WIDTH-1:0] pfloor);
        wait_idle();
        write_reg(REG_NUM_DIMS, CFG_WIDTH'(dims));
        write_reg(REG_GAMMA_M1, gm1);
        write_reg(REG_INV_GAMMA_M1, inv);
        write_reg(REG_P_FLOOR, pfloor);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            faces_to_send.push_back(random_face());
    endtask

    initial begin
        q_t one;
        q_t top;
        q_t bot;
        one = q_t'(1 << 20);
        top = 32'sh7FFF_FFFF;
        bot = 32'sh8000_0000;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed faces under the reset gas constants
        faces_to_send.push_back(make_face('0, '0, '0, '0, '0, '0, '0, '0));
        faces_to_send.push_back(make_face(top, top, top, top, top, top, top, top));
        faces_to_send.push_back(make_face(bot, bot, bot, bot, bot, bot, bot, bot));
        faces_to_send.push_back(make_face(one, one, '0, '0, 10 * one, one, '0, '0));
        faces_to_send.push_back(make_face(one, 2 * one, one, one, '0, one, one, one));
        faces_to_send.push_back(make_face(one, one, one, one, -one, '0, '0, one));
        faces_to_send.push_back(make_face(-one, one, -one, one, 4 * one, one, -one, one));
        faces_to_send.push_back(make_face('0, one, one, one, 2 * one, one, one, one));
        faces_to_send.push_back(make_face('0, -one, '0, '0, one, one, '0, '0));
        faces_to_send.push_back(make_face(q_t'(1), top, bot, top, top, top, bot, top));
        faces_to_send.push_back(make_face(one, '0, '0, '0, '0, one, one, one));
        faces_to_send.push_back(make_face(top, '0, '0, '0, bot, bot, top, '0));
        queue_random(200);

        set_gas(DIMS_TWO, GAMMA_M1_RST, INV_GAMMA_M1_RST, P_FLOOR_RST);
        faces_to_send.push_back(make_face(one, one, one, top, 3 * one, one, one, top));
        queue_random(220);

        set_gas(2'd0, 31'h7FFF_FFFF, '0, '0);
        queue_random(200);

        set_gas(2'd1, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_random(200);

        set_gas(DIMS_TWO, 31'd524288, 31'd2097152, 31'd1048576);
        queue_random(220);

        set_gas(NUM_DIMS_RST, 31'd419430, 31'd2621440, 31'($urandom_range(0, 1 << 22)));
        queue_random(250);

        wait_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
